>>> rtl/hcs_pkg.sv
package hcs_pkg;

  // Fixed field widths.
  localparam int INDEX_W       = 20;
  localparam int BOX_W         = 16;
  localparam int PT_W          = 17;
  localparam int INDEX_LOG_MAX = 10;
  localparam int SPAN_W        = 18;

  // Orientation codes at the top digit, chosen by the parity of the digit count.
  localparam logic [1:0] ORIENT_EVEN_START = 2'd0;
  localparam logic [1:0] ORIENT_ODD_START  = 2'd1;

  // Digit tables, indexed by {orientation, digit}.
  localparam logic [15:0] XBIT_TAB = 16'b0011_1001_1100_0110;
  localparam logic [15:0] YBIT_TAB = 16'b1001_0011_0110_1100;
  localparam logic [1:0] NXT_ORIENT [16] = '{
    2'd1, 2'd0, 2'd0, 2'd3,
    2'd0, 2'd1, 2'd1, 2'd2,
    2'd3, 2'd2, 2'd2, 2'd1,
    2'd2, 2'd3, 2'd3, 2'd0
  };

  // Per-request data that rides along the digit chain.
  typedef struct packed {
    logic [INDEX_W-1:0]      idx;
    logic                    last;
    logic                    clip;
    logic signed [BOX_W-1:0] min_x;
    logic signed [BOX_W-1:0] min_y;
  } hcs_tag_t;

endpackage

>>> rtl/hilbert_curve_scan_generator.sv
// Hilbert curve scan generator. Each input request yields one grid point of
// a Hilbert walk over the smallest power-of-two square (side at least 2, at
// most 2^min(ORDER,10)) that covers the configured box, offset by the box
// minimum. The block takes one request per cycle and returns one point per
// cycle while the output is not stalled; each point passes through the chain
// of digit cells, one per base-4 digit, and then the output register. Box
// registers are written through the cfg port, which is always ready, and
// should only change while no request is in flight. A restart request starts
// again at index zero, and the index wraps after the last point of the
// square. The clipped flag marks a box larger than the largest square.
module hilbert_curve_scan_generator
  import hcs_pkg::*;
#(
  parameter int ORDER = 10
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [2:0]              cfg_index,
  input  logic [BOX_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_restart,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [PT_W-1:0]  out_point_x,
  output logic signed [PT_W-1:0]  out_point_y,
  output logic [INDEX_W-1:0]      out_curve_index,
  output logic                    out_last,
  output logic                    out_clipped
);

  localparam int NDIG = (ORDER < INDEX_LOG_MAX) ? ORDER : INDEX_LOG_MAX;
  localparam int XW   = NDIG;
  localparam logic [1:0] START_ORIENT =
    (NDIG % 2 == 1) ? ORIENT_ODD_START : ORIENT_EVEN_START;

  localparam logic [2:0] REG_MIN_X = 3'd0;
  localparam logic [2:0] REG_MIN_Y = 3'd1;
  localparam logic [2:0] REG_MAX_X = 3'd2;
  localparam logic [2:0] REG_MAX_Y = 3'd3;

  logic signed [BOX_W-1:0]  box_min_x_r;
  logic signed [BOX_W-1:0]  box_min_y_r;
  logic signed [BOX_W-1:0]  box_max_x_r;
  logic signed [BOX_W-1:0]  box_max_y_r;
  logic [INDEX_W-1:0]       next_index_r;
  logic [INDEX_W-1:0]       next_index_nxt;

  logic signed [SPAN_W-1:0] span_x;
  logic signed [SPAN_W-1:0] span_y;
  logic signed [SPAN_W-1:0] span;
  logic [4:0]               lg;
  logic [INDEX_W-1:0]       sq_mask;
  logic                     clip;
  logic [INDEX_W-1:0]       idx;
  logic                     last;
  logic                     en;
  logic                     in_acc;

  logic                     valid_w  [NDIG+1];
  hcs_tag_t                 tag_w    [NDIG+1];
  logic [1:0]               orient_w [NDIG+1];
  logic [XW-1:0]            x_w      [NDIG+1];
  logic [XW-1:0]            y_w      [NDIG+1];

  logic                     out_valid_r;
  logic signed [PT_W-1:0]   out_point_x_r;
  logic signed [PT_W-1:0]   out_point_y_r;
  logic [INDEX_W-1:0]       out_curve_index_r;
  logic                     out_last_r;
  logic                     out_clipped_r;
  logic signed [PT_W-1:0]   point_x_nxt;
  logic signed [PT_W-1:0]   point_y_nxt;

  // Whole chain advances unless a finished point is waiting.
  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Box register writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_min_x_r <= '0;
      box_min_y_r <= '0;
      box_max_x_r <= BOX_W'(1);
      box_max_y_r <= BOX_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MIN_X: box_min_x_r <= cfg_data;
        REG_MIN_Y: box_min_y_r <= cfg_data;
        REG_MAX_X: box_max_x_r <= cfg_data;
        REG_MAX_Y: box_max_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Box spans and the larger of the two.
  assign span_x = $signed({{2{box_max_x_r[BOX_W-1]}}, box_max_x_r}) + SPAN_W'(1)
                - $signed({{2{box_min_x_r[BOX_W-1]}}, box_min_x_r});
  assign span_y = $signed({{2{box_max_y_r[BOX_W-1]}}, box_max_y_r}) + SPAN_W'(1)
                - $signed({{2{box_min_y_r[BOX_W-1]}}, box_min_y_r});
  assign span   = (span_x > span_y) ? span_x : span_y;
  assign clip   = span > $signed(SPAN_W'(1) << NDIG);

  // Smallest side exponent that covers the span, saturating at the chain depth.
  always_comb begin
    lg = 5'(NDIG);
    for (int j = NDIG; j >= 1; j--) begin
      if (span <= $signed(SPAN_W'(1) << j)) begin
        lg = 5'(j);
      end
    end
  end

  // Mask of valid index bits for the current square.
  always_comb begin
    for (int b = 0; b < INDEX_W; b++) begin
      sq_mask[b] = (6'(b) < {lg, 1'b0});
    end
  end

  // Index of this request, with restart and out-of-square wrap.
  assign idx  = (in_restart || ((next_index_r & ~sq_mask) != '0)) ? '0 : next_index_r;
  assign last = (idx == sq_mask);
  assign next_index_nxt = last ? '0 : idx + INDEX_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_index_r <= '0;
    end else if (in_acc) begin
      next_index_r <= next_index_nxt;
    end
  end

  // Head of the digit chain.
  assign valid_w[0]        = in_valid;
  assign tag_w[0].idx      = idx;
  assign tag_w[0].last     = last;
  assign tag_w[0].clip     = clip;
  assign tag_w[0].min_x    = box_min_x_r;
  assign tag_w[0].min_y    = box_min_y_r;
  assign orient_w[0]       = START_ORIENT;
  assign x_w[0]            = '0;
  assign y_w[0]            = '0;

  // One cell per base-4 digit, most significant first.
  for (genvar i = 0; i < NDIG; i++) begin : g_cell
    hcs_digit_cell #(
      .XW  (XW),
      .POS (NDIG - 1 - i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (en),
      .in_valid   (valid_w[i]),
      .in_tag     (tag_w[i]),
      .in_orient  (orient_w[i]),
      .in_x       (x_w[i]),
      .in_y       (y_w[i]),
      .out_valid  (valid_w[i+1]),
      .out_tag    (tag_w[i+1]),
      .out_orient (orient_w[i+1]),
      .out_x      (x_w[i+1]),
      .out_y      (y_w[i+1])
    );
  end

  // Offset by the box minimum.
  assign point_x_nxt = $signed({{(PT_W-XW){1'b0}}, x_w[NDIG]})
                     + $signed({tag_w[NDIG].min_x[BOX_W-1], tag_w[NDIG].min_x});
  assign point_y_nxt = $signed({{(PT_W-XW){1'b0}}, y_w[NDIG]})
                     + $signed({tag_w[NDIG].min_y[BOX_W-1], tag_w[NDIG].min_y});

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= valid_w[NDIG];
    end
  end

  always_ff @(posedge clk) begin
    if (en && valid_w[NDIG]) begin
      out_point_x_r     <= point_x_nxt;
      out_point_y_r     <= point_y_nxt;
      out_curve_index_r <= tag_w[NDIG].idx;
      out_last_r        <= tag_w[NDIG].last;
      out_clipped_r     <= tag_w[NDIG].clip;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_point_x     = out_point_x_r;
  assign out_point_y     = out_point_y_r;
  assign out_curve_index = out_curve_index_r;
  assign out_last        = out_last_r;
  assign out_clipped     = out_clipped_r;

  // A restart request always moves the walk on to index one.
  a_restart_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_restart |=> next_index_r == INDEX_W'(1))
    else $error("restart did not advance to index one");

  // The final point of any square has its low digit all ones.
  a_last_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> out_curve_index_r[1] && out_curve_index_r[0])
    else $error("last flag on an index that cannot end a square");

  // Index zero maps to the box minimum column.
  a_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_curve_index_r == '0) |->
      out_point_x_r == $signed({box_min_x_r[BOX_W-1], box_min_x_r}))
    else $error("curve origin not at box minimum");

endmodule

>>> rtl/hcs_digit_cell.sv
module hcs_digit_cell
  import hcs_pkg::*;
#(
  parameter int XW  = 10,
  parameter int POS = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  hcs_tag_t      in_tag,
  input  logic [1:0]    in_orient,
  input  logic [XW-1:0] in_x,
  input  logic [XW-1:0] in_y,
  output logic          out_valid,
  output hcs_tag_t      out_tag,
  output logic [1:0]    out_orient,
  output logic [XW-1:0] out_x,
  output logic [XW-1:0] out_y
);

  logic [1:0]    digit;
  logic [3:0]    k;
  logic [XW:0]   x_cat;
  logic [XW:0]   y_cat;
  logic          valid_r;
  hcs_tag_t      tag_r;
  logic [1:0]    orient_r;
  logic [XW-1:0] x_r;
  logic [XW-1:0] y_r;

  // Look up this cell's digit and shift the new coordinate bits in at the bottom.
  assign digit = in_tag.idx[2*POS +: 2];
  assign k     = {in_orient, digit};
  assign x_cat = {in_x, XBIT_TAB[k]};
  assign y_cat = {in_y, YBIT_TAB[k]};

  // Valid bit of this stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  // Payload of this stage.
  always_ff @(posedge clk) begin
    if (en) begin
      tag_r    <= in_tag;
      orient_r <= NXT_ORIENT[k];
      x_r      <= x_cat[XW-1:0];
      y_r      <= y_cat[XW-1:0];
    end
  end

  assign out_valid  = valid_r;
  assign out_tag    = tag_r;
  assign out_orient = orient_r;
  assign out_x      = x_r;
  assign out_y      = y_r;

endmodule

>>> tb/hilbert_point_checker.sv
`timescale 1ns / 100ps

package hcs_tb_pkg;

  // Register map of the box configuration port.
  typedef enum logic [2:0] {
    REG_BOX_MIN_X = 3'd0,
    REG_BOX_MIN_Y = 3'd1,
    REG_BOX_MAX_X = 3'd2,
    REG_BOX_MAX_Y = 3'd3
  } box_reg_t;

  // First register index that the block does not decode.
  localparam int REG_COUNT = 4;

endpackage

module hilbert_point_checker
  import hcs_pkg::*;
  import hcs_tb_pkg::*;
#(
  parameter int ORDER = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [2:0]             cfg_index,
  input  logic [BOX_W-1:0]       cfg_data,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic                   in_restart,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic signed [PT_W-1:0] out_point_x,
  input  logic signed [PT_W-1:0] out_point_y,
  input  logic [INDEX_W-1:0]     out_curve_index,
  input  logic                   out_last,
  input  logic                   out_clipped,
  output int                     mismatches,
  output int                     pending
);

  // One point of the walk as the block should return it.
  typedef struct packed {
    logic signed [PT_W-1:0] x;
    logic signed [PT_W-1:0] y;
    logic [INDEX_W-1:0]     index;
    logic                   last;
    logic                   clipped;
  } scan_point_t;

  // Digit state machine: slot = orientation + digit. Entry 0 sits at the right.
  localparam logic [63:0] NEXT_ORIENT_TAB = {
    4'd0, 4'd12, 4'd12, 4'd8, 4'd4, 4'd8, 4'd8, 4'd12,
    4'd8, 4'd4,  4'd4,  4'd0, 4'd12, 4'd0, 4'd0, 4'd4
  };
  localparam logic [15:0] COL_BIT_TAB = 16'b0011_1001_1100_0110;
  localparam logic [15:0] ROW_BIT_TAB = 16'b1001_0011_0110_1100;
  localparam int START_EVEN = 0;
  localparam int START_ODD  = 4;
  localparam int SLOT_COUNT = 16;

  // Largest side is 2^SIDE_LOG_CAP; a 20-bit index cannot count beyond 2^20 points, a side of 2^10.
  localparam int SIDE_LOG_RAW = (ORDER < INDEX_LOG_MAX) ? ORDER : INDEX_LOG_MAX;
  localparam int SIDE_LOG_CAP = (SIDE_LOG_RAW < 1) ? 1 : SIDE_LOG_RAW;
  localparam int MAX_PRINTED  = 40;

  logic signed [BOX_W-1:0] lo_x, lo_y, hi_x, hi_y;
  logic [INDEX_W-1:0]      walk_index;
  scan_point_t             expected_points[$];
  int                      error_count = 0;

  assign mismatches = error_count;

  // Print one line for a mismatch and count it; printing stops after a while.
  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (error_count < MAX_PRINTED) begin
      $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    end
    error_count++;
  endtask

  // Work out the point for one request from the box and the walk position.
  function automatic scan_point_t predict_scan_point(input logic restart,
                                                     input logic [INDEX_W-1:0] from_index);
    scan_point_t        p;
    int                 base_x, base_y, span, span_y, side_log;
    int                 digits, orient, slot, i, col, row;
    longint             total;
    logic [INDEX_W-1:0] idx, rest;
    base_x = int'(lo_x);
    base_y = int'(lo_y);
    span   = int'(hi_x) + 1 - base_x;
    span_y = int'(hi_y) + 1 - base_y;
    if (span_y > span) begin
      span = span_y;
    end
    p.clipped = (span > (1 << SIDE_LOG_CAP));
    side_log = 1;
    while (side_log < SIDE_LOG_CAP && (1 << side_log) < span) begin
      side_log++;
    end
    total = longint'(1) << (2 * side_log);

    // A restart, or a position left outside a shrunken square, starts over.
    idx = from_index;
    if (restart || idx >= total) begin
      idx = '0;
    end
    p.last  = (idx == total - 1);
    p.index = idx;

    // The start orientation follows the parity of the significant digit count.
    digits = 0;
    rest   = idx;
    while (rest != '0) begin
      rest = rest >> 2;
      digits++;
    end
    orient = (digits % 2 != 0) ? START_ODD : START_EVEN;
    col = 0;
    row = 0;
    for (i = digits - 1; i >= 0; i--) begin
      slot   = (orient + int'(idx[2*i +: 2])) % SLOT_COUNT;
      col    = col | (int'(COL_BIT_TAB[slot]) << i);
      row    = row | (int'(ROW_BIT_TAB[slot]) << i);
      orient = int'(NEXT_ORIENT_TAB[4*slot +: 4]);
    end
    p.x = PT_W'(col + base_x);
    p.y = PT_W'(row + base_y);
    return p;
  endfunction

  // Track box writes, predict on each request, compare on each returned point.
  always @(posedge clk) begin
    scan_point_t fresh, want;
    if (!rst_n) begin
      lo_x       = '0;
      lo_y       = '0;
      hi_x       = 16'sd1;
      hi_y       = 16'sd1;
      walk_index = '0;
      expected_points.delete();
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BOX_MIN_X: lo_x = cfg_data;
          REG_BOX_MIN_Y: lo_y = cfg_data;
          REG_BOX_MAX_X: hi_x = cfg_data;
          REG_BOX_MAX_Y: hi_y = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        fresh      = predict_scan_point(in_restart, walk_index);
        walk_index = fresh.last ? '0 : fresh.index + 1'b1;
        expected_points.insert(expected_points.size(), fresh);
      end
      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          report_mismatch("point with no request waiting, index", out_curve_index, -1);
        end else begin
          want = expected_points.pop_front();
          if (out_point_x !== want.x) begin
            report_mismatch("point_x", out_point_x, want.x);
          end
          if (out_point_y !== want.y) begin
            report_mismatch("point_y", out_point_y, want.y);
          end
          if (out_curve_index !== want.index) begin
            report_mismatch("curve_index", out_curve_index, want.index);
          end
          if (out_last !== want.last) begin
            report_mismatch("last", out_last, want.last);
          end
          if (out_clipped !== want.clipped) begin
            report_mismatch("clipped", out_clipped, want.clipped);
          end
        end
      end
      pending <= expected_points.size();
    end
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb
  import hcs_pkg::*;
  import hcs_tb_pkg::*;
();

  localparam int ORDER           = 10;
  localparam int LATENCY         = ((ORDER < INDEX_LOG_MAX) ? ORDER : INDEX_LOG_MAX) + 1;
  localparam int RANDOM_ITEMS    = 1950;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int STALL_LIMIT     = 5000;
  localparam int RESET_CYCLES    = 6;

  typedef enum logic {RX_STEADY, RX_CHOPPY} rx_pattern_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [2:0]             cfg_index;
  logic [BOX_W-1:0]       cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic                   in_restart;
  logic                   out_valid;
  logic                   out_ready;
  logic signed [PT_W-1:0] out_point_x;
  logic signed [PT_W-1:0] out_point_y;
  logic [INDEX_W-1:0]     out_curve_index;
  logic                   out_last;
  logic                   out_clipped;

  int          mismatches;
  int          pending;
  int          items_sent   = 0;
  int          idle_cycles  = 0;
  int          stall_left   = 0;
  rx_pattern_t rx_pattern   = RX_STEADY;
  logic        hold_off_req = 1'b0;

  hilbert_curve_scan_generator #(
    .ORDER(ORDER)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_restart     (in_restart),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_point_x    (out_point_x),
    .out_point_y    (out_point_y),
    .out_curve_index(out_curve_index),
    .out_last       (out_last),
    .out_clipped    (out_clipped)
  );

  hilbert_point_checker #(
    .ORDER(ORDER)
  ) point_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_restart     (in_restart),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_point_x    (out_point_x),
    .out_point_y    (out_point_y),
    .out_curve_index(out_curve_index),
    .out_last       (out_last),
    .out_clipped    (out_clipped),
    .mismatches     (mismatches),
    .pending        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: steady, or short random stalls, or one long hold-off on request.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        out_ready <= 1'b1;
      end else if (!rst_n || rx_pattern == RX_STEADY) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(0, 7);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when nothing moves on any channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("** hilbert_curve_scan_generator: FAILED **");
      $finish;
    end
  end

  // Offer one request and hold it until it is accepted.
  task automatic send_point(input logic restart);
    in_valid   <= 1'b1;
    in_restart <= restart;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Stop offering and wait until every predicted point has come back.
  task automatic drain_points();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Write one box register; cfg_valid is left high for a following write.
  task automatic write_box_reg(input logic [2:0] index, input logic [BOX_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_box(input logic [BOX_W-1:0] min_x, input logic [BOX_W-1:0] min_y,
                         input logic [BOX_W-1:0] max_x, input logic [BOX_W-1:0] max_y);
    write_box_reg(REG_BOX_MIN_X, min_x);
    write_box_reg(REG_BOX_MIN_Y, min_y);
    write_box_reg(REG_BOX_MAX_X, max_x);
    write_box_reg(REG_BOX_MAX_Y, max_y);
    cfg_valid <= 1'b0;
  endtask

  // Mostly small boxes so walks reach their last point, now and then huge or wild ones.
  task automatic pick_random_box();
    logic [BOX_W-1:0] min_x, min_y;
    int               span_x, span_y;
    if ($urandom_range(0, 3) == 0) begin
      write_box_reg(3'($urandom_range(REG_COUNT, (1 << $bits(cfg_index)) - 1)),
                    16'($urandom));
    end
    case ($urandom_range(0, 9))
      0: begin
        set_box(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      end
      1: begin
        set_box(16'($urandom_range(32768, 33768)), 16'($urandom_range(32768, 33768)),
                16'($urandom_range(31767, 32767)), 16'($urandom_range(31767, 32767)));
      end
      default: begin
        span_x = $urandom_range(1, 16);
        span_y = $urandom_range(1, 16);
        if ($urandom_range(0, 4) == 0) begin
          span_x = $urandom_range(17, 40);
        end
        min_x = 16'($urandom);
        min_y = 16'($urandom);
        set_box(min_x, min_y, min_x + 16'(span_x - 1), min_y + 16'(span_y - 1));
      end
    endcase
  endtask

  // Send a run of requests, in bursts with random gaps when asked.
  task automatic send_run(input int count, input int restart_per_mille, input bit bursty);
    int burst_left, k;
    burst_left = $urandom_range(1, 24);
    for (k = 0; k < count; k++) begin
      send_point($urandom_range(0, 999) < restart_per_mille);
      if (bursty) begin
        burst_left--;
        if (burst_left == 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk);
          burst_left = $urandom_range(1, 24);
        end
      end
    end
  endtask

  // Stimulus: directed corners first, then random phases of box settings.
  initial begin
    int directed_count, phase, restart_per_mille, run_len;
    bit bursty;
    rst_n      <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= REG_BOX_MIN_X;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    in_restart <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Reset box gives a 2x2 square: walk past the last point and restart mid-walk.
    repeat (5) send_point(1'b0);
    send_point(1'b1);
    send_point(1'b0);
    drain_points();

    // Full 16-bit range saturates the side and sets clipped.
    set_box(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
    repeat (5) send_point(1'b0);
    drain_points();

    // Single-cell box at the top edge: the walk sits past the square and wraps.
    set_box(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    repeat (2) send_point(1'b0);
    drain_points();

    // Inverted box falls back to the smallest square.
    set_box(16'h7fff, 16'h7fff, 16'h8000, 16'h8000);
    repeat (2) send_point(1'b0);
    drain_points();

    // A span of exactly the largest side is not clipped; one more cell is.
    set_box(16'h0000, 16'h0000, 16'd1023, 16'd1023);
    send_point(1'b1);
    repeat (2) send_point(1'b0);
    drain_points();
    set_box(16'hffff, 16'h0000, 16'd1023, 16'h0000);
    repeat (2) send_point(1'b0);
    drain_points();

    // Writes to undecoded register indexes must leave the box alone.
    write_box_reg(3'(REG_COUNT), 16'h0000);
    write_box_reg(3'((1 << $bits(cfg_index)) - 1), 16'h0000);
    cfg_valid <= 1'b0;
    repeat (2) send_point(1'b0);
    drain_points();
    directed_count = items_sent;

    // Random phases; each starts once every point of the previous one is back.
    phase = 0;
    while (items_sent < directed_count + RANDOM_ITEMS) begin
      drain_points();
      pick_random_box();
      rx_pattern = ($urandom_range(0, 2) == 0) ? RX_STEADY : RX_CHOPPY;
      bursty     = ($urandom_range(0, 3) != 0);
      case (phase % 4)
        0: restart_per_mille = 0;
        1: restart_per_mille = 10;
        2: restart_per_mille = 300;
        default: restart_per_mille = 3;
      endcase
      // One phase keeps offering back to back while the receiver holds off.
      if (phase == 2) begin
        hold_off_req = 1'b1;
        bursty       = 1'b0;
      end
      // The last run stops at the planned number of requests.
      run_len = $urandom_range(60, 200);
      if (run_len > directed_count + RANDOM_ITEMS - items_sent) begin
        run_len = directed_count + RANDOM_ITEMS - items_sent;
      end
      send_run(run_len, restart_per_mille, bursty);
      phase++;
    end

    drain_points();
    repeat (2 * LATENCY) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("** hilbert_curve_scan_generator: PASSED **");
    end else begin
      $display("** hilbert_curve_scan_generator: FAILED **");
    end
    $finish;
  end

endmodule
